// ===== hw/rtl/cbt_pkg.sv =====
// shared types, codes and constants of the csv byte tokenizer
package cbt_pkg;

    localparam int COLUMN_BITS = 16;
    localparam int ROW_BITS    = 24;
    localparam int TOTAL_BITS  = 32;

    localparam logic [7:0] SEPARATOR_RESET = 8'd44;
    localparam logic [7:0] CH_QUOTE        = 8'h22;
    localparam logic [7:0] CH_LF           = 8'h0A;
    localparam logic [7:0] CH_CR           = 8'h0D;

    localparam int OP_QUEUE_DEPTH  = 2;
    localparam int RES_QUEUE_DEPTH = 2;

    // result kinds
    localparam logic [1:0] KIND_CHAR     = 2'd0;
    localparam logic [1:0] KIND_CELL_END = 2'd1;
    localparam logic [1:0] KIND_ROW_END  = 2'd2;
    localparam logic [1:0] KIND_SUMMARY  = 2'd3;

    // operations handed from the front to the back
    typedef enum logic [1:0] {
        OP_CHAR     = 2'd0,
        OP_CELL     = 2'd1,
        OP_CELL_ROW = 2'd2,
        OP_EOD      = 2'd3
    } t_op_code;

    typedef struct packed {
        t_op_code   code;
        logic [7:0] ch;
        logic       cell_text;
        logic       close_cell;
        logic       open_quote;
    } t_op;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_of_data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]             kind;
        logic [7:0]             char_out;
        logic [COLUMN_BITS-1:0] column;
        logic [ROW_BITS-1:0]    row;
        logic                   cell_empty;
        logic                   last;
        logic                   open_quote;
        logic [TOTAL_BITS-1:0]  filled_cells;
        logic [TOTAL_BITS-1:0]  empty_cells;
        logic [ROW_BITS-1:0]    max_row;
        logic [COLUMN_BITS-1:0] max_column;
    } t_result;

endpackage

// ===== hw/rtl/csv_byte_tokenizer.sv =====
// top level of the csv byte tokenizer: front end, operation queue, back end, result queue
// a byte's operation is registered in the operation queue, the back end turns the queue head
// into its first result, and that result is registered in the result queue for popping
// one byte per cycle while the operation queue has room; one result per cycle from the back end
// while the result queue has room; a line end makes a cell end and a row end, end of data up to three
// reset: synchronous active low; clears parse mode, counters, statistics and both
// queues, and sets the separator back to comma
module csv_byte_tokenizer import cbt_pkg::*; #(
    parameter int P_OP_QUEUE_DEPTH  = OP_QUEUE_DEPTH,
    parameter int P_RES_QUEUE_DEPTH = RES_QUEUE_DEPTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration: separator byte
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    // input queue side
    input  logic       push,
    output logic       full,
    input  t_in_item   i_data,
    // result queue side
    output logic       empty,
    input  logic       pop,
    output t_result    o_data
);

    logic    accept;
    logic    fr_op_valid;
    t_op     fr_op;
    logic    opq_empty;
    logic    opq_full;
    t_op     opq_head;
    logic    bk_op_pop;
    logic    bk_res_push;
    t_result bk_res;
    logic    resq_full;

    // an input transaction happens when push is high and the operation queue has room
    assign accept = push && !full;
    assign full   = opq_full;

    // front: tracks quoting and line endings, turns each byte into at most one operation
    cbt_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (accept),
        .i_item     (i_data),
        .o_op_valid (fr_op_valid),
        .o_op       (fr_op)
    );

    // operations waiting for the back end; bytes that cause nothing never enter
    cbt_fifo #(
        .WIDTH ($bits(t_op)),
        .DEPTH (P_OP_QUEUE_DEPTH)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_op_valid),
        .i_data  (fr_op),
        .o_full  (opq_full),
        .i_pop   (bk_op_pop),
        .o_data  (opq_head),
        .o_empty (opq_empty)
    );

    // back: one result per cycle while the result queue has room, counters and statistics live here
    cbt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!opq_empty),
        .i_op       (opq_head),
        .o_op_pop   (bk_op_pop),
        .i_res_full (resq_full),
        .o_res_push (bk_res_push),
        .o_res      (bk_res)
    );

    // result queue decouples the back end from the consumer
    cbt_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (P_RES_QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_res_push),
        .i_data  (bk_res),
        .o_full  (resq_full),
        .i_pop   (pop),
        .o_data  (o_data),
        .o_empty (empty)
    );

endmodule

// ===== hw/rtl/cbt_fifo.sv =====
// small register based synchronous queue
module cbt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hw/rtl/cbt_front.sv =====
// front end: quote state machine and byte classification into operations
module cbt_front import cbt_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_accept,
    input  t_in_item   i_item,
    output logic       o_op_valid,
    output t_op        o_op
);

    localparam logic [1:0] MODE_NORMAL     = 2'd0;
    localparam logic [1:0] MODE_QUOTED     = 2'd1;
    localparam logic [1:0] MODE_QUOTE_SEEN = 2'd2;

    logic [7:0] r_separator;
    logic [1:0] r_mode, n_mode;
    logic       r_pending, n_pending;
    logic       r_text, n_text;

    logic       is_quote, is_sep, is_lf, is_cr;
    logic [7:0] b;

    assign b        = i_item.byte_in;
    assign is_quote = (b == CH_QUOTE);
    assign is_sep   = (b == r_separator);
    assign is_lf    = (b == CH_LF);
    assign is_cr    = (b == CH_CR);

    always_comb begin
        n_mode     = r_mode;
        n_pending  = 1'b0;
        n_text     = r_text;
        o_op_valid = 1'b0;
        o_op.code       = OP_CHAR;
        o_op.ch         = b;
        o_op.cell_text  = r_text;
        o_op.close_cell = r_text || (r_mode == MODE_QUOTED) || (r_mode == MODE_QUOTE_SEEN);
        o_op.open_quote = (r_mode == MODE_QUOTED);
        if (i_item.end_of_data) begin
            o_op_valid = 1'b1;
            o_op.code  = OP_EOD;
            n_mode     = MODE_NORMAL;
            n_text     = 1'b0;
        end else begin
            unique case (r_mode)
                MODE_QUOTED: begin
                    if (is_quote) begin
                        n_mode = MODE_QUOTE_SEEN;
                    end else begin
                        o_op_valid = 1'b1;
                        n_text     = 1'b1;
                    end
                end
                MODE_QUOTE_SEEN: begin
                    priority if (is_quote) begin
                        o_op_valid = 1'b1;
                        n_text     = 1'b1;
                        n_mode     = MODE_QUOTED;
                    end else if (is_sep) begin
                        o_op_valid = 1'b1;
                        o_op.code  = OP_CELL;
                        n_text     = 1'b0;
                        n_mode     = MODE_NORMAL;
                    end else if (is_lf || is_cr) begin
                        o_op_valid = 1'b1;
                        o_op.code  = OP_CELL_ROW;
                        n_text     = 1'b0;
                        n_mode     = MODE_NORMAL;
                        n_pending  = is_cr;
                    end else begin
                        o_op_valid = 1'b1;
                        n_text     = 1'b1;
                        n_mode     = MODE_NORMAL;
                    end
                end
                default: begin
                    // normal mode, and the unused code behaves the same
                    n_mode = MODE_NORMAL;
                    priority if (is_quote) begin
                        n_mode = MODE_QUOTED;
                    end else if (is_sep) begin
                        o_op_valid = 1'b1;
                        o_op.code  = OP_CELL;
                        n_text     = 1'b0;
                    end else if (is_lf) begin
                        // lf right after a line-ending cr is swallowed
                        if (!r_pending) begin
                            o_op_valid = 1'b1;
                            o_op.code  = OP_CELL_ROW;
                            n_text     = 1'b0;
                        end
                    end else if (is_cr) begin
                        o_op_valid = 1'b1;
                        o_op.code  = OP_CELL_ROW;
                        n_text     = 1'b0;
                        n_pending  = 1'b1;
                    end else begin
                        o_op_valid = 1'b1;
                        n_text     = 1'b1;
                    end
                end
            endcase
        end
        o_op_valid = o_op_valid && i_accept;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_separator <= SEPARATOR_RESET;
            r_mode      <= MODE_NORMAL;
            r_pending   <= 1'b0;
            r_text      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_separator <= i_cfg_data;
            end
            if (i_accept) begin
                r_mode    <= n_mode;
                r_pending <= n_pending;
                r_text    <= n_text;
            end
        end
    end

endmodule

// ===== hw/rtl/cbt_back.sv =====
// back end: expands operations into results and keeps counters and statistics
module cbt_back import cbt_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_op_valid,
    input  t_op     i_op,
    output logic    o_op_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam logic [1:0] PH_CHAR = 2'd0;
    localparam logic [1:0] PH_CELL = 2'd1;
    localparam logic [1:0] PH_ROW  = 2'd2;
    localparam logic [1:0] PH_SUM  = 2'd3;

    localparam logic [1:0] STEP_START = 2'd0;
    localparam logic [1:0] STEP_ROW   = 2'd1;
    localparam logic [1:0] STEP_SUM   = 2'd2;

    logic [COLUMN_BITS-1:0] r_col, n_col;
    logic [ROW_BITS-1:0]    r_row, n_row;
    logic [TOTAL_BITS-1:0]  r_filled, n_filled;
    logic [TOTAL_BITS-1:0]  r_empty, n_empty;
    logic [ROW_BITS-1:0]    r_row_mark, n_row_mark;
    logic [COLUMN_BITS-1:0] r_col_mark, n_col_mark;
    logic [1:0]             r_step, n_step;

    logic [1:0]             phase;
    logic                   is_last;
    logic                   fire;
    logic [COLUMN_BITS-1:0] col_inc;
    logic [ROW_BITS-1:0]    row_inc;
    logic [COLUMN_BITS-1:0] col_mark_a;

    assign col_inc = (r_col == '1) ? r_col : r_col + COLUMN_BITS'(1);
    assign row_inc = (r_row == '1) ? r_row : r_row + ROW_BITS'(1);
    assign col_mark_a = (r_col_mark < r_col) ? r_col : r_col_mark;

    always_comb begin
        phase   = PH_CHAR;
        is_last = 1'b1;
        unique case (i_op.code)
            OP_CHAR: phase = PH_CHAR;
            OP_CELL: phase = PH_CELL;
            OP_CELL_ROW: begin
                phase   = (r_step == STEP_START) ? PH_CELL : PH_ROW;
                is_last = (r_step != STEP_START);
            end
            OP_EOD: begin
                priority if (r_step == STEP_START && i_op.close_cell) begin
                    phase = PH_CELL;
                end else if (r_step != STEP_SUM && r_col != '0) begin
                    phase = PH_ROW;
                end else begin
                    phase = PH_SUM;
                end
                is_last = (phase == PH_SUM);
            end
            default: phase = PH_CHAR;
        endcase
    end

    assign fire       = i_op_valid && !i_res_full;
    assign o_res_push = fire;
    assign o_op_pop   = fire && is_last;

    always_comb begin
        n_col      = r_col;
        n_row      = r_row;
        n_filled   = r_filled;
        n_empty    = r_empty;
        n_row_mark = r_row_mark;
        n_col_mark = r_col_mark;
        n_step     = r_step;

        o_res              = '0;
        o_res.last         = is_last;
        o_res.column       = r_col;
        o_res.row          = r_row;

        unique case (phase)
            PH_CHAR: begin
                o_res.kind     = KIND_CHAR;
                o_res.char_out = i_op.ch;
            end
            PH_CELL: begin
                o_res.kind       = KIND_CELL_END;
                o_res.cell_empty = !i_op.cell_text;
                n_col_mark       = col_mark_a;
                if (i_op.cell_text) begin
                    if (r_row_mark < row_inc) begin
                        n_row_mark = row_inc;
                    end
                    if (col_mark_a < col_inc) begin
                        n_col_mark = col_inc;
                    end
                    n_filled = (r_filled == '1) ? r_filled : r_filled + TOTAL_BITS'(1);
                end else begin
                    n_empty = (r_empty == '1) ? r_empty : r_empty + TOTAL_BITS'(1);
                end
                n_col  = col_inc;
                n_step = STEP_ROW;
            end
            PH_ROW: begin
                o_res.kind = KIND_ROW_END;
                if (r_row_mark < r_row) begin
                    n_row_mark = r_row;
                end
                n_row  = row_inc;
                n_col  = '0;
                n_step = STEP_SUM;
            end
            default: begin
                o_res.kind         = KIND_SUMMARY;
                o_res.column       = '0;
                o_res.row          = '0;
                o_res.open_quote   = i_op.open_quote;
                o_res.filled_cells = r_filled;
                o_res.empty_cells  = r_empty;
                o_res.max_row      = r_row_mark;
                o_res.max_column   = r_col_mark;
            end
        endcase
        if (is_last) begin
            n_step = STEP_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_filled   <= '0;
            r_empty    <= '0;
            r_row_mark <= '0;
            r_col_mark <= '0;
            r_step     <= STEP_START;
        end else if (fire) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_filled   <= n_filled;
            r_empty    <= n_empty;
            r_row_mark <= n_row_mark;
            r_col_mark <= n_col_mark;
            r_step     <= n_step;
        end
    end

endmodule
